// File: rtl/core/rps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rps_pkg;
  localparam int unsigned NTASK = 8;
  localparam int unsigned TW = 3;
  localparam logic [TW-1:0] IDLE_TASK = 3'd7;

  localparam logic [3:0] CMD_INIT    = 4'd0;
  localparam logic [3:0] CMD_READY   = 4'd1;
  localparam logic [3:0] CMD_SUSPEND = 4'd2;
  localparam logic [3:0] CMD_RESUME  = 4'd3;
  localparam logic [3:0] CMD_DELAY   = 4'd4;
  localparam logic [3:0] CMD_TICK    = 4'd5;
  localparam logic [3:0] CMD_IRQ_IN  = 4'd6;
  localparam logic [3:0] CMD_IRQ_OUT = 4'd7;
  localparam logic [3:0] CMD_LOCK    = 4'd8;
  localparam logic [3:0] CMD_UNLOCK  = 4'd9;
  localparam logic [3:0] CMD_PEND    = 4'd10;
  localparam logic [3:0] CMD_ACCEPT  = 4'd11;
  localparam logic [3:0] CMD_POST    = 4'd12;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_IN_IRQ  = 3'd1;
  localparam logic [2:0] ST_LOCKED  = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  typedef struct packed {
    logic       start;
  } tick_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] expired;
  } tick_rsp_t;

  function automatic logic [TW-1:0] first_set(input logic [7:0] map);
    logic [TW-1:0] r;
    r = IDLE_TASK;
    for (int i = NTASK - 1; i >= 0; i--) begin
      if (map[i]) r = TW'(i);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/rps_delay_walk.sv
`timescale 1ns / 1ps
`default_nettype none
// Delay counter bank; one decrement/compare unit walks the counters on a tick.
module rps_delay_walk (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rps_pkg::tick_req_t req_i,
  input  wire logic               clr_all_i,
  input  wire logic               wr_i,
  input  wire logic [2:0]         wr_idx_i,
  input  wire logic [15:0]        wr_val_i,
  output rps_pkg::tick_rsp_t      rsp_o
);
  logic [15:0] cnt_q [rps_pkg::NTASK];
  logic [2:0]  idx_q;
  logic        busy_q, done_q;
  logic [7:0]  exp_q;
  logic [15:0] dec;

  assign dec = cnt_q[idx_q] - 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rps_pkg::NTASK; i++) cnt_q[i] <= '0;
      idx_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      exp_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (clr_all_i) begin
        for (int i = 0; i < rps_pkg::NTASK; i++) cnt_q[i] <= '0;
      end else if (wr_i) begin
        cnt_q[wr_idx_i] <= wr_val_i;
      end
      if (req_i.start) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        exp_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q[idx_q] != 16'd0) begin
          cnt_q[idx_q] <= dec;
          if (dec == 16'd0) exp_q[idx_q] <= 1'b1;
        end
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'(rps_pkg::NTASK - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.expired = exp_q;

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> $past(busy_q)) else $error("done without walk");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("tick restarted mid walk");
  a_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> idx_q == 3'd0) else $error("walk start index");
`endif
endmodule
`default_nettype wire

// File: rtl/core/rtos_priority_scheduler_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Signals                         | Payload
// s_axis   | in  | tvalid/tready/tdata[23:0]       | cmd[3:0] task_req[6:4] ticks[22:7]
// m_axis   | out | tvalid/tready/tdata[31:0]       | see port comment
// cfg      | in  | cfg_valid/cfg_ready/cfg_data[7:0] | sem_initial_count
// Non-tick commands pass through the execute state to the result; tick also
// waits for the walk: one counter per cycle, shared decrement unit, 8 counters.
// Async active-low reset clears all kernel state; cur task is idle.
// Input is held off while a command is in work or its result is unclaimed.
module rtos_priority_scheduler_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // cmd, task_req, ticks, pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // status, switched, cur_task, sem_value,
                                          // timeout_mask, ready_mask, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_q;
  logic [3:0]  cmd_q;
  logic [2:0]  treq_q;
  logic [15:0] ticks_q;
  logic [7:0]  cfg_q, ready_q, irq_q, lock_q, sem_q, wait_q;
  logic [2:0]  cur_q;
  logic [2:0]  st_q;
  logic        sw_q;
  logic [7:0]  semv_q, tmask_q;

  rps_pkg::tick_req_t treq;
  rps_pkg::tick_rsp_t trsp;
  logic        clr_all, dwr;
  logic [2:0]  dwr_idx;
  logic [15:0] dwr_val;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {1'b0, ready_q, tmask_q, semv_q, cur_q, sw_q, st_q};

  // decoded effects of the held command
  logic [7:0] rdy_n, irq_n, lock_n, sem_n, wait_n, semv_n;
  logic [2:0] st_n, post_t;
  logic       resch;
  logic [7:0] tbit, cbit;

  always_comb begin
    tbit   = 8'd1 << treq_q;
    cbit   = 8'd1 << cur_q;
    post_t = rps_pkg::first_set(wait_q);
    rdy_n = ready_q; irq_n = irq_q; lock_n = lock_q; sem_n = sem_q;
    wait_n = wait_q; st_n = rps_pkg::ST_OK; resch = 1'b0;
    clr_all = 1'b0; dwr = 1'b0; dwr_idx = treq_q; dwr_val = '0;
    case (cmd_q)
      rps_pkg::CMD_INIT: begin
        rdy_n = 8'd1 << rps_pkg::IDLE_TASK; irq_n = '0; lock_n = '0; sem_n = cfg_q;
        wait_n = '0; clr_all = 1'b1;
      end
      rps_pkg::CMD_READY: begin
        dwr = 1'b1; rdy_n = ready_q | tbit;
      end
      rps_pkg::CMD_SUSPEND: begin
        dwr = 1'b1; rdy_n = ready_q & ~tbit; resch = (cur_q == treq_q);
      end
      rps_pkg::CMD_RESUME: begin
        dwr = 1'b1; rdy_n = ready_q | tbit; resch = (cur_q > treq_q);
      end
      rps_pkg::CMD_DELAY: begin
        if (irq_q != 0) st_n = rps_pkg::ST_IN_IRQ;
        else if (ticks_q != 0) begin
          rdy_n = ready_q & ~cbit; dwr = 1'b1; dwr_idx = cur_q;
          dwr_val = ticks_q; resch = 1'b1;
        end
      end
      rps_pkg::CMD_TICK: ;
      rps_pkg::CMD_IRQ_IN: if (irq_q != 8'hFF) irq_n = irq_q + 8'd1;
      rps_pkg::CMD_IRQ_OUT: begin
        if (irq_q != 0) irq_n = irq_q - 8'd1;
        resch = 1'b1;
      end
      rps_pkg::CMD_LOCK: begin
        if (irq_q != 0) st_n = rps_pkg::ST_IN_IRQ;
        else if (lock_q != 8'hFF) lock_n = lock_q + 8'd1;
      end
      rps_pkg::CMD_UNLOCK: begin
        if (lock_q == 0) st_n = rps_pkg::ST_IGNORED;
        else begin lock_n = lock_q - 8'd1; resch = 1'b1; end
      end
      rps_pkg::CMD_PEND: begin
        if (irq_q != 0) st_n = rps_pkg::ST_IN_IRQ;
        else if (lock_q != 0) st_n = rps_pkg::ST_LOCKED;
        else if (sem_q != 0) sem_n = sem_q - 8'd1;
        else begin
          wait_n = wait_q | cbit; rdy_n = ready_q & ~cbit; dwr = 1'b1;
          dwr_idx = cur_q; dwr_val = ticks_q; resch = 1'b1;
          st_n = rps_pkg::ST_BLOCKED;
        end
      end
      rps_pkg::CMD_ACCEPT: if (sem_q != 0) sem_n = sem_q - 8'd1;
      rps_pkg::CMD_POST: begin
        if (wait_q != 0) begin
          wait_n = wait_q & ~(8'd1 << post_t); dwr = 1'b1; dwr_idx = post_t;
          rdy_n = ready_q | (8'd1 << post_t); resch = (cur_q > post_t);
        end else if (sem_q != 8'hFF) sem_n = sem_q + 8'd1;
      end
      default: st_n = rps_pkg::ST_IGNORED;
    endcase
    // task index beyond the task set cannot occur at 3 bits with 8 tasks
    if (!(state_q == S_EXEC)) begin clr_all = 1'b0; dwr = 1'b0; end
    semv_n = (cmd_q == rps_pkg::CMD_ACCEPT) ? sem_q : sem_n;
  end

  assign treq.start   = (state_q == S_EXEC) && (cmd_q == rps_pkg::CMD_TICK);

  rps_delay_walk u_walk (
    .clk_i, .rst_ni, .req_i(treq), .clr_all_i(clr_all), .wr_i(dwr),
    .wr_idx_i(dwr_idx), .wr_val_i(dwr_val), .rsp_o(trsp)
  );

  logic [2:0] next_cur;
  assign next_cur = (resch && irq_n == 0 && lock_n == 0) ?
                    rps_pkg::first_set(rdy_n) : cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_q <= '0; ready_q <= '0; irq_q <= '0; lock_q <= '0; sem_q <= '0;
      wait_q <= '0; cur_q <= rps_pkg::IDLE_TASK;
      cmd_q <= '0; treq_q <= '0; ticks_q <= '0;
      st_q <= '0; sw_q <= 1'b0; semv_q <= '0; tmask_q <= '0;
    end else begin
      if (cfg_valid && cfg_ready) cfg_q <= cfg_data;
      case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          cmd_q   <= s_axis_tdata[3:0];
          treq_q  <= s_axis_tdata[6:4];
          ticks_q <= s_axis_tdata[22:7];
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          st_q <= st_n; tmask_q <= '0;
          if (cmd_q == rps_pkg::CMD_TICK) begin
            sw_q <= 1'b0; semv_q <= sem_q;
            state_q <= S_TICK;
          end else begin
            ready_q <= rdy_n; irq_q <= irq_n; lock_q <= lock_n;
            sem_q <= sem_n; wait_q <= wait_n; semv_q <= semv_n;
            if (cmd_q == rps_pkg::CMD_INIT) begin
              cur_q <= rps_pkg::IDLE_TASK;
              sw_q  <= (cur_q != rps_pkg::IDLE_TASK);
            end else begin
              cur_q <= next_cur;
              sw_q  <= (next_cur != cur_q);
            end
            state_q <= S_OUT;
          end
        end
        S_TICK: if (trsp.done) begin
          ready_q <= ready_q | trsp.expired;
          wait_q  <= wait_q & ~trsp.expired;
          tmask_q <= wait_q & trsp.expired;
          state_q <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_tick_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK) |-> $stable(cur_q)) else $error("tick moved task");
  a_walk_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trsp.busy |-> state_q == S_TICK) else $error("walk outside tick");
  a_tmask_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (tmask_q & ~ready_q) == 8'd0) else $error("timeout not ready");
`endif
endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0] ready_mask;
  logic [7:0] timeout_mask;
  logic [7:0] sem_value;
  logic [2:0] cur_task;
  logic       switched;
  logic [2:0] status;
} sched_result_t;

class sched_scoreboard;
  logic [7:0]    rdy_bits;
  logic [15:0]   delays [rps_pkg::NTASK];
  logic [2:0]    cur;
  logic [7:0]    irq_nest;
  logic [7:0]    lock_nest;
  logic [7:0]    count;
  logic [7:0]    waiters;
  logic [7:0]    init_count;
  sched_result_t pending_q[$];
  int            errors;

  function void clear_state();
    rdy_bits = '0;
    foreach (delays[i]) delays[i] = '0;
    cur = rps_pkg::IDLE_TASK;
    irq_nest = '0;
    lock_nest = '0;
    count = '0;
    waiters = '0;
    init_count = '0;
    errors = 0;
  endfunction

  function logic [2:0] highest(logic [7:0] map);
    for (int i = 0; i < rps_pkg::NTASK; i++) begin
      if (map[i]) return 3'(i);
    end
    return rps_pkg::IDLE_TASK;
  endfunction

  function void pick_next();
    if (irq_nest == 0 && lock_nest == 0) cur = highest(rdy_bits);
  endfunction

  // predict the result of one accepted command transaction
  function void note(logic [3:0] cmd, logic [2:0] tsk, logic [15:0] ticks);
    sched_result_t r;
    logic [2:0]    prev;
    logic [7:0]    semv;
    logic [2:0]    w;
    prev = cur;
    r = '0;
    r.status = rps_pkg::ST_OK;
    semv = count;
    case (cmd)
      rps_pkg::CMD_INIT: begin
        rdy_bits = 8'd1 << rps_pkg::IDLE_TASK;
        foreach (delays[i]) delays[i] = '0;
        irq_nest = '0;
        lock_nest = '0;
        count = init_count;
        waiters = '0;
        cur = rps_pkg::IDLE_TASK;
      end
      rps_pkg::CMD_READY: begin
        delays[tsk] = '0;
        rdy_bits[tsk] = 1'b1;
      end
      rps_pkg::CMD_SUSPEND: begin
        delays[tsk] = '0;
        rdy_bits[tsk] = 1'b0;
        if (cur == tsk) pick_next();
      end
      rps_pkg::CMD_RESUME: begin
        delays[tsk] = '0;
        rdy_bits[tsk] = 1'b1;
        if (cur > tsk) pick_next();
      end
      rps_pkg::CMD_DELAY: begin
        if (irq_nest != 0) r.status = rps_pkg::ST_IN_IRQ;
        else if (ticks != 0) begin
          rdy_bits[cur] = 1'b0;
          delays[cur] = ticks;
          pick_next();
        end
      end
      rps_pkg::CMD_TICK: begin
        for (int i = 0; i < rps_pkg::NTASK; i++) begin
          if (delays[i] != 0) begin
            delays[i]--;
            if (delays[i] == 0) begin
              rdy_bits[i] = 1'b1;
              if (waiters[i]) begin
                waiters[i] = 1'b0;
                r.timeout_mask[i] = 1'b1;
              end
            end
          end
        end
      end
      rps_pkg::CMD_IRQ_IN: if (irq_nest != 8'hFF) irq_nest++;
      rps_pkg::CMD_IRQ_OUT: begin
        if (irq_nest != 0) irq_nest--;
        pick_next();
      end
      rps_pkg::CMD_LOCK: begin
        if (irq_nest != 0) r.status = rps_pkg::ST_IN_IRQ;
        else if (lock_nest != 8'hFF) lock_nest++;
      end
      rps_pkg::CMD_UNLOCK: begin
        if (lock_nest == 0) r.status = rps_pkg::ST_IGNORED;
        else begin
          lock_nest--;
          pick_next();
        end
      end
      rps_pkg::CMD_PEND: begin
        if (irq_nest != 0) r.status = rps_pkg::ST_IN_IRQ;
        else if (lock_nest != 0) r.status = rps_pkg::ST_LOCKED;
        else if (count != 0) count--;
        else begin
          waiters[cur] = 1'b1;
          rdy_bits[cur] = 1'b0;
          delays[cur] = ticks;
          pick_next();
          r.status = rps_pkg::ST_BLOCKED;
        end
      end
      rps_pkg::CMD_ACCEPT: if (count != 0) count--;
      rps_pkg::CMD_POST: begin
        if (waiters != 0) begin
          w = highest(waiters);
          waiters[w] = 1'b0;
          delays[w] = '0;
          rdy_bits[w] = 1'b1;
          if (cur > w) pick_next();
        end else if (count != 8'hFF) count++;
      end
      default: r.status = rps_pkg::ST_IGNORED;
    endcase
    // accept reports the count before taking
    if (cmd != rps_pkg::CMD_ACCEPT) semv = count;
    r.switched = (cur != prev);
    r.cur_task = cur;
    r.sem_value = semv;
    r.ready_mask = rdy_bits;
    pending_q.push_back(r);
  endfunction

  task report(string what, int got, int want);
    $display("mismatch %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task check(logic [31:0] data);
    sched_result_t got;
    sched_result_t want;
    got = data[30:0];
    if (pending_q.size() == 0) begin
      report("unexpected transaction", int'(data), 0);
      return;
    end
    want = pending_q.pop_front();
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.switched != want.switched) report("switched", got.switched, want.switched);
    if (got.cur_task != want.cur_task) report("cur_task", got.cur_task, want.cur_task);
    if (got.sem_value != want.sem_value) report("sem_value", got.sem_value, want.sem_value);
    if (got.timeout_mask != want.timeout_mask)
      report("timeout_mask", got.timeout_mask, want.timeout_mask);
    if (got.ready_mask != want.ready_mask)
      report("ready_mask", got.ready_mask, want.ready_mask);
  endtask
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 900000;
  localparam int PHASE_ITEMS = 376;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // cmd[3:0] task_req[6:4] ticks[22:7] pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // status[2:0] switched[3] cur_task[6:4] sem_value[14:7]
                              // timeout_mask[22:15] ready_mask[30:23] pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  sched_scoreboard sb = new();
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_now = 1'b0;
  int  rx_wait = 0;

  rtos_priority_scheduler_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // sink side: random back-pressure, plus one long hold on request
  always @(posedge clk_i) begin
    if (hold_now) begin
      hold_now = 1'b0;
      rx_wait = 300;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_wait = pick_gap();
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  task automatic send_cmd(logic [3:0] cmd, logic [2:0] tsk, logic [15:0] ticks);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, ticks, tsk, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(cmd, tsk, ticks);
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_init_count(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    sb.init_count = v;
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random();
    int r;
    logic [15:0] t;
    logic [3:0] c;
    r = $urandom_range(0, 99);
    t = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    if (r < 1) c = rps_pkg::CMD_INIT;
    else if (r < 7) c = rps_pkg::CMD_READY;
    else if (r < 12) c = rps_pkg::CMD_SUSPEND;
    else if (r < 18) c = rps_pkg::CMD_RESUME;
    else if (r < 28) c = rps_pkg::CMD_DELAY;
    else if (r < 50) c = rps_pkg::CMD_TICK;
    else if (r < 54) c = rps_pkg::CMD_IRQ_IN;
    else if (r < 59) c = rps_pkg::CMD_IRQ_OUT;
    else if (r < 63) c = rps_pkg::CMD_LOCK;
    else if (r < 68) c = rps_pkg::CMD_UNLOCK;
    else if (r < 80) c = rps_pkg::CMD_PEND;
    else if (r < 86) c = rps_pkg::CMD_ACCEPT;
    else if (r < 98) c = rps_pkg::CMD_POST;
    else c = 4'($urandom_range(13, 15));
    send_cmd(c, 3'($urandom_range(0, 7)), t);
  endtask

  initial begin
    logic [7:0] counts [5];
    sb.clear_state();
    counts[0] = 8'd0;
    counts[1] = 8'hFF;
    counts[2] = 8'd1;
    counts[3] = 8'($urandom_range(2, 254));
    counts[4] = 8'($urandom_range(0, 3));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    write_init_count(8'd2);
    send_cmd(rps_pkg::CMD_TICK, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_INIT, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_READY, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_RESUME, 3'd3, 16'd0);
    send_cmd(rps_pkg::CMD_SUSPEND, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_DELAY, 3'd7, 16'hFFFF);
    send_cmd(rps_pkg::CMD_DELAY, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_PEND, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_ACCEPT, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_ACCEPT, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_PEND, 3'd0, 16'd2);
    send_cmd(rps_pkg::CMD_TICK, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_TICK, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_PEND, 3'd7, 16'd0);
    send_cmd(rps_pkg::CMD_POST, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_POST, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_IRQ_IN, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_LOCK, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_DELAY, 3'd0, 16'd5);
    send_cmd(rps_pkg::CMD_PEND, 3'd0, 16'd5);
    send_cmd(rps_pkg::CMD_IRQ_OUT, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_LOCK, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_PEND, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_UNLOCK, 3'd0, 16'd0);
    send_cmd(rps_pkg::CMD_UNLOCK, 3'd0, 16'd0);
    send_cmd(4'd15, 3'd7, 16'hFFFF);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_init_count(counts[p]);
      quiet = (p == 3);
      if (p == 2) hold_now = 1'b1;
      send_cmd(rps_pkg::CMD_INIT, 3'd0, 16'd0);
      repeat (PHASE_ITEMS) send_random();
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
